// ----- src/first_fit_page_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator_macros
// Assertion macros used by the allocator top-level RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and codes shared by the first-fit page allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int DATA_W     = 32;
    localparam int PB_W       = 17;
    localparam int PIU_W      = 7;
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;
    localparam int REM_W      = PB_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd2;

    localparam logic [PB_W-1:0]  PAGE_BYTES_RST   = 17'd4096;
    localparam logic [PIU_W-1:0] PAGES_IN_USE_RST = 7'd64;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_ZERO_SIZE = 2'd2,
        STAT_BAD_ADDR  = 2'd3
    } status_t;

    typedef struct packed {
        logic is_free;
        logic linked;
    } page_entry_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_DIV,
        OP_EVAL,
        OP_SCAN,
        OP_MARK,
        OP_CHAIN,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic zero_req;
        logic div_last;
        logic eval_fail;
        logic is_release;
        logic scan_found;
        logic scan_fail;
        logic mark_last;
        logic chain_last;
        logic out_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_EVAL,
        S_SCAN,
        S_MARK,
        S_CHAIN,
        S_DONE
    } ctrl_state_t;

endpackage

`default_nettype wire

// ----- src/first_fit_page_allocator.sv -----
// Sequence: a zero-size allocate goes straight to the result; other requests run the
//   32-step divider, then an allocate scans the page flags for a free run and marks each
//   granted page, while a free clears its linked chain; a failed check ends at once.
// Throughput: one request in flight; the next is taken the cycle after the result loads.
// Reset: a clearing pass marks every page free; requests
//   stall during it, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// First-fit contiguous page allocator with linked runs over a page pool.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_page_allocator_macros.svh"

module first_fit_page_allocator import ffpa_pkg::*; #(
    parameter int MAX_PAGES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [DATA_W-1:0]    request_bytes,
    input  wire logic [DATA_W-1:0]    release_address,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic [DATA_W-1:0]         granted_address
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    assign cfg_ready = 1'b1;

    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffpa_dp #(
        .MAX_PAGES (MAX_PAGES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .cmd             (cmd),
        .sts             (sts),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .granted_address (granted_address)
    );

    `FFPA_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && !in_stall, in_stall, "request accepted while previous one still in progress")
    `FFPA_ASSERT_NOW(a_grant_only_on_ok, clk, rst_n, out_valid && (status != STAT_OK), granted_address == '0, "nonzero address on a failed or free request")
    `FFPA_ASSERT_NEXT(a_result_loaded, clk, rst_n, cmd.op == OP_OUT, out_valid, "result not presented after load")

endmodule

`default_nettype wire

// ----- src/ffpa_ram.sv -----
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/ffpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Request sequencer: clear pass, divide, evaluate, scan/mark or chain free.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_ctrl import ffpa_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = sts.zero_req ? S_DONE : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (sts.div_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.op = OP_EVAL;
                priority if (sts.eval_fail)
                begin
                    state_next = S_DONE;
                end
                else if (sts.is_release)
                begin
                    state_next = S_CHAIN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                priority if (sts.scan_fail)
                begin
                    state_next = S_DONE;
                end
                else if (sts.scan_found)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.op = OP_MARK;
                if (sts.mark_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CHAIN:
            begin
                cmd.op = OP_CHAIN;
                if (sts.chain_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ffpa_dp.sv -----
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: config registers, restoring divider, page flag RAM walk, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffpa_dp import ffpa_pkg::*; #(
    parameter int MAX_PAGES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 mode,
    input  wire logic [DATA_W-1:0]    request_bytes,
    input  wire logic [DATA_W-1:0]    release_address,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                sts,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [1:0]                status,
    output logic [DATA_W-1:0]         granted_address
);

    localparam int IDX_W = $clog2(MAX_PAGES + 1);
    localparam int AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int EW    = $bits(page_entry_t);
    localparam int PW    = IDX_W + PB_W;

    // configuration
    logic [PB_W-1:0]   page_bytes_reg;
    logic [PIU_W-1:0]  pages_in_use_reg;
    logic [DATA_W-1:0] pool_base_reg;

    // control-side registers
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // payload registers
    logic                 mode_reg, mode_next;
    logic [DATA_W-1:0]    div_q_reg, div_q_next;
    logic [REM_W-1:0]     div_rem_reg, div_rem_next;
    logic [IDX_W-1:0]     need_reg, need_next;
    logic [IDX_W-1:0]     run_len_reg, run_len_next;
    logic [IDX_W-1:0]     run_start_reg, run_start_next;
    logic [IDX_W-1:0]     base_reg, base_next;
    logic [PW-1:0]        prod_reg;
    status_t              res_status_reg, res_status_next;
    status_t              out_status_reg, out_status_next;
    logic [DATA_W-1:0]    out_granted_reg, out_granted_next;

    logic [PB_W-1:0]   pb_eff;
    logic [IDX_W-1:0]  count_eff;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    pb_ext;
    logic              trial_ge;
    logic              rem_nz;
    logic [DATA_W:0]   need_wide;
    logic              alloc_fail;
    logic              free_fail;
    logic [IDX_W-1:0]  run_len_inc;
    logic              scan_fail;
    logic              scan_found;
    logic              mark_last;
    logic              chain_last;
    logic              clear_last;
    logic              out_free;
    page_entry_t       rd_entry;
    page_entry_t       wr_entry;
    logic              ram_we;
    logic [EW-1:0]     ram_rdata;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg   <= PAGE_BYTES_RST;
            pages_in_use_reg <= PAGES_IN_USE_RST;
            pool_base_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAGE_BYTES:   page_bytes_reg   <= cfg_data[PB_W-1:0];
                CFG_PAGES_IN_USE: pages_in_use_reg <= cfg_data[PIU_W-1:0];
                CFG_POOL_BASE:    pool_base_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign pb_eff = (page_bytes_reg == '0) ? PB_W'(1) : page_bytes_reg;

    always_comb
    begin
        if (32'(pages_in_use_reg) > 32'(MAX_PAGES))
        begin
            count_eff = IDX_W'(MAX_PAGES);
        end
        else
        begin
            count_eff = IDX_W'(pages_in_use_reg);
        end
    end

    // one restoring divide step
    assign pb_ext   = (REM_W + 1)'(pb_eff);
    assign trial    = {div_rem_reg, div_q_reg[DATA_W-1]};
    assign trial_ge = (trial >= pb_ext);

    assign rem_nz     = (div_rem_reg != '0);
    assign need_wide  = {1'b0, div_q_reg} + (DATA_W + 1)'(rem_nz);
    assign alloc_fail = (need_wide > (DATA_W + 1)'(count_eff));
    assign free_fail  = rem_nz || (div_q_reg >= DATA_W'(count_eff));

    assign rd_entry    = page_entry_t'(ram_rdata);
    assign run_len_inc = run_len_reg + IDX_W'(1);
    assign scan_fail   = (idx_reg >= count_eff);
    assign scan_found  = !scan_fail && rd_entry.is_free && (run_len_inc == need_reg);
    assign mark_last   = (run_len_inc == need_reg);
    assign clear_last  = (idx_reg == IDX_W'(MAX_PAGES - 1));
    assign chain_last  = !rd_entry.linked || clear_last;
    assign out_free    = !out_valid_reg || !out_stall;

    assign sts.clear_last = clear_last;
    assign sts.zero_req   = !mode && (request_bytes == '0);
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.eval_fail  = mode_reg ? free_fail : alloc_fail;
    assign sts.is_release = mode_reg;
    assign sts.scan_found = scan_found;
    assign sts.scan_fail  = scan_fail;
    assign sts.mark_last  = mark_last;
    assign sts.chain_last = chain_last;
    assign sts.out_free   = out_free;

    always_comb
    begin
        idx_next         = idx_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        div_q_next       = div_q_reg;
        div_rem_next     = div_rem_reg;
        need_next        = need_reg;
        run_len_next     = run_len_reg;
        run_start_next   = run_start_reg;
        base_next        = base_reg;
        res_status_next  = res_status_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        ram_we           = 1'b0;
        wr_entry         = '{is_free: 1'b1, linked: 1'b0};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (cmd.op)
            OP_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = clear_last ? '0 : idx_reg + IDX_W'(1);
            end
            OP_LOAD:
            begin
                mode_next    = mode;
                div_cnt_next = '0;
                div_rem_next = '0;
                div_q_next   = mode ? (release_address - pool_base_reg) : request_bytes;
                res_status_next = (!mode && (request_bytes == '0)) ? STAT_ZERO_SIZE
                                                                   : STAT_OK;
            end
            OP_DIV:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                div_q_next   = {div_q_reg[DATA_W-2:0], trial_ge};
                div_rem_next = trial_ge ? REM_W'(trial - pb_ext) : trial[REM_W-1:0];
            end
            OP_EVAL:
            begin
                need_next      = need_wide[IDX_W-1:0];
                run_len_next   = '0;
                run_start_next = '0;
                idx_next       = mode_reg ? div_q_reg[IDX_W-1:0] : '0;
                if (mode_reg ? free_fail : alloc_fail)
                begin
                    res_status_next = mode_reg ? STAT_BAD_ADDR : STAT_NO_SPACE;
                end
            end
            OP_SCAN:
            begin
                priority if (scan_fail)
                begin
                    res_status_next = STAT_NO_SPACE;
                end
                else if (scan_found)
                begin
                    base_next    = run_start_reg;
                    idx_next     = run_start_reg;
                    run_len_next = '0;
                end
                else if (rd_entry.is_free)
                begin
                    run_len_next = run_len_inc;
                    idx_next     = idx_reg + IDX_W'(1);
                end
                else
                begin
                    run_len_next   = '0;
                    run_start_next = idx_reg + IDX_W'(1);
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            OP_MARK:
            begin
                ram_we       = 1'b1;
                wr_entry     = '{is_free: 1'b0, linked: !mark_last};
                run_len_next = run_len_inc;
                idx_next     = idx_reg + IDX_W'(1);
            end
            OP_CHAIN:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
            end
            OP_OUT:
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status_reg;
                if ((res_status_reg == STAT_OK) && !mode_reg)
                begin
                    out_granted_next = pool_base_reg + DATA_W'(prod_reg);
                end
                else
                begin
                    out_granted_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        div_q_reg       <= div_q_next;
        div_rem_reg     <= div_rem_next;
        need_reg        <= need_next;
        run_len_reg     <= run_len_next;
        run_start_reg   <= run_start_next;
        base_reg        <= base_next;
        prod_reg        <= {{PB_W{1'b0}}, base_reg} * {{IDX_W{1'b0}}, pb_eff};
        res_status_reg  <= res_status_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
    end

    // read address is idx_next so the registered rdata lines up with idx_reg
    ffpa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PAGES)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (idx_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = out_granted_reg;

endmodule

`default_nettype wire

// ----- verif/first_fit_page_allocator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_test
// Self-checking bench for the first-fit page allocator. A short list of
// directed requests covers sizes at the field limits, zero-size and oversize
// allocations, bad free addresses, frees inside a run and of free pages. Then
// several pool settings are applied in turn, each with mostly well-formed
// allocate/free traffic plus noise, under different valid/stall patterns.
// Each result is checked against pinned values or an in-bench page-flag model.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_test;
    import ffpa_pkg::*;

    localparam int   MAX_PAGES  = 64;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam int   NUM_ROWS   = 22;
    localparam int   NUM_PHASES = 8;

    typedef struct packed {
        status_t     status;
        logic [31:0] granted;
    } alloc_result_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] bytes;
        logic [31:0] addr;
        logic        pinned;
        status_t     status;
        logic [31:0] granted;
    } request_row_t;

    typedef struct packed {
        logic [31:0] page_bytes_word;
        logic [31:0] pages_word;
        logic [31:0] base_word;
        int          idle;
        int          stall;
        int          items;
    } pool_phase_t;

    logic                 clk;
    logic                 rst_n           = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [DATA_W-1:0]    cfg_data        = '0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic                 mode            = MODE_ALLOC;
    logic [DATA_W-1:0]    request_bytes   = '0;
    logic [DATA_W-1:0]    release_address = '0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [1:0]           status;
    logic [DATA_W-1:0]    granted_address;

    // model state
    logic [PB_W-1:0]  page_bytes_reg = PAGE_BYTES_RST;
    logic [PIU_W-1:0] pages_reg      = PAGES_IN_USE_RST;
    logic [31:0]      pool_base_reg  = '0;
    logic             page_is_free [MAX_PAGES];
    logic             page_linked  [MAX_PAGES];

    alloc_result_t pending_results [$];
    logic [31:0]   granted_bases   [$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int requests_sent;
    int status_seen [4];

    first_fit_page_allocator #(
        .MAX_PAGES(MAX_PAGES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .release_address(release_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .granted_address(granted_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        for (int p = 0; p < MAX_PAGES; p++)
        begin
            page_is_free[p] = 1'b1;
            page_linked[p]  = 1'b0;
        end
    end

    function automatic request_row_t row_of(input logic m, input logic [31:0] bytes,
                                            input logic [31:0] addr, input logic pinned,
                                            input status_t st, input logic [31:0] granted);
        request_row_t r;
        r.mode    = m;
        r.bytes   = bytes;
        r.addr    = addr;
        r.pinned  = pinned;
        r.status  = st;
        r.granted = granted;
        return r;
    endfunction

    function automatic pool_phase_t phase_of(input logic [31:0] pb, input logic [31:0] pages,
                                             input logic [31:0] base, input int idle,
                                             input int stall, input int items);
        pool_phase_t ph;
        ph.page_bytes_word = pb;
        ph.pages_word      = pages;
        ph.base_word       = base;
        ph.idle            = idle;
        ph.stall           = stall;
        ph.items           = items;
        return ph;
    endfunction

    // Updates the page flags and returns the result of one request.
    function automatic alloc_result_t predict_allocation(input logic m, input logic [31:0] bytes,
                                                         input logic [31:0] addr);
        logic [63:0]   pb;
        logic [63:0]   need;
        logic [63:0]   offset;
        logic [63:0]   addr64;
        logic [31:0]   off32;
        int            count;
        int            n;
        int            first;
        int            i;
        int            k;
        bit            found;
        bit            clear_run;
        alloc_result_t r;
        pb        = (page_bytes_reg == '0) ? 64'd1 : {47'd0, page_bytes_reg};
        count     = (pages_reg > 7'd64) ? MAX_PAGES : int'(pages_reg);
        r.status  = STAT_OK;
        r.granted = '0;
        if (m == MODE_ALLOC)
        begin
            if (bytes == '0)
                r.status = STAT_ZERO_SIZE;
            else
            begin
                need  = ({32'd0, bytes} + pb - 64'd1) / pb;
                found = 1'b0;
                first = 0;
                n     = 0;
                if (need <= count)
                begin
                    n = int'(need);
                    for (i = 0; i + n <= count && !found; i++)
                    begin
                        clear_run = 1'b1;
                        for (k = 0; k < n; k++)
                            if (!page_is_free[i + k])
                                clear_run = 1'b0;
                        if (clear_run)
                        begin
                            found = 1'b1;
                            first = i;
                        end
                    end
                end
                if (found)
                begin
                    for (k = 0; k < n; k++)
                    begin
                        page_is_free[first + k] = 1'b0;
                        page_linked[first + k]  = (k + 1 < n);
                    end
                    addr64    = {32'd0, pool_base_reg} + first * pb;
                    r.granted = addr64[31:0];
                end
                else
                    r.status = STAT_NO_SPACE;
            end
        end
        else
        begin
            off32  = addr - pool_base_reg;
            offset = {32'd0, off32};
            if (offset % pb != 0 || offset / pb >= count)
                r.status = STAT_BAD_ADDR;
            else
            begin
                i = int'(offset / pb);
                page_is_free[i] = 1'b1;
                while (page_linked[i] && i + 1 < MAX_PAGES)
                begin
                    page_linked[i] = 1'b0;
                    i++;
                    page_is_free[i] = 1'b1;
                end
                page_linked[i] = 1'b0;
            end
        end
        return r;
    endfunction

    // Valid stays high until the request is taken; the model runs on acceptance.
    task automatic issue_request(input logic m, input logic [31:0] bytes,
                                 input logic [31:0] addr, input request_row_t pin);
        alloc_result_t r;
        mode            <= m;
        request_bytes   <= bytes;
        release_address <= addr;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_allocation(m, bytes, addr);
        if (m == MODE_ALLOC && r.status == STAT_OK)
        begin
            granted_bases.push_back(r.granted);
            if (granted_bases.size() > 64)
                void'(granted_bases.pop_front());
        end
        if (pin.pinned)
        begin
            r.status  = pin.status;
            r.granted = pin.granted;
        end
        pending_results.push_back(r);
        requests_sent++;
    endtask

    task automatic pause_sender();
        if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(160, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Caller lowers cfg_valid after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PAGE_BYTES:   page_bytes_reg = data[PB_W-1:0];
            CFG_PAGES_IN_USE: pages_reg      = data[PIU_W-1:0];
            CFG_POOL_BASE:    pool_base_reg  = data;
            default:          ;
        endcase
    endtask

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d, granted_address %h",
                       status, granted_address);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[status]++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (granted_address !== want.granted)
                begin
                    $error("granted_address: expected %h, actual %h",
                           want.granted, granted_address);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        request_row_t directed_rows [NUM_ROWS];
        pool_phase_t  phases [NUM_PHASES];
        request_row_t no_pin;
        logic         m;
        logic [31:0]  bytes;
        logic [31:0]  addr;
        logic [63:0]  pb;
        logic [63:0]  wide;
        int           cnt;
        int           n;
        int           j;
        int           roll;

        no_pin = row_of(MODE_ALLOC, '0, '0, 1'b0, STAT_OK, '0);

        // reset pool: 64 pages of 4 KiB at address zero
        directed_rows[0]  = row_of(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF, 1'b1, STAT_ZERO_SIZE, '0);
        directed_rows[1]  = row_of(MODE_ALLOC, 32'd1, 32'h0, 1'b1, STAT_OK, 32'h0);
        directed_rows[2]  = row_of(MODE_ALLOC, 32'd4096, 32'h0, 1'b1, STAT_OK, 32'h1000);
        directed_rows[3]  = row_of(MODE_ALLOC, 32'd4097, 32'h0, 1'b1, STAT_OK, 32'h2000);
        directed_rows[4]  = row_of(MODE_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1, STAT_NO_SPACE, '0);
        directed_rows[5]  = row_of(MODE_FREE, 32'hFFFF_FFFF, 32'h1001, 1'b1, STAT_BAD_ADDR, '0);
        directed_rows[6]  = row_of(MODE_FREE, 32'h0, 32'h4_0000, 1'b1, STAT_BAD_ADDR, '0);
        directed_rows[7]  = row_of(MODE_FREE, 32'h0, 32'hFFFF_FFFF, 1'b1, STAT_BAD_ADDR, '0);
        directed_rows[8]  = row_of(MODE_FREE, 32'hFFFF_FFFF, 32'h3000, 1'b1, STAT_OK, '0);
        directed_rows[9]  = row_of(MODE_ALLOC, 32'd100, 32'hFFFF_FFFF, 1'b0, STAT_OK, '0);
        directed_rows[10] = row_of(MODE_FREE, 32'h0, 32'h2000, 1'b0, STAT_OK, '0);
        directed_rows[11] = row_of(MODE_FREE, 32'h0, 32'h5000, 1'b1, STAT_OK, '0);
        directed_rows[12] = row_of(MODE_ALLOC, 32'h4_0000, 32'h0, 1'b0, STAT_OK, '0);
        directed_rows[13] = row_of(MODE_FREE, 32'h0, 32'h0, 1'b1, STAT_OK, '0);
        directed_rows[14] = row_of(MODE_FREE, 32'h0, 32'h1000, 1'b1, STAT_OK, '0);
        directed_rows[15] = row_of(MODE_ALLOC, 32'h4_0000, 32'h0, 1'b0, STAT_OK, '0);
        directed_rows[16] = row_of(MODE_FREE, 32'h0, 32'h3_F000, 1'b0, STAT_OK, '0);
        directed_rows[17] = row_of(MODE_FREE, 32'h0, 32'h0, 1'b0, STAT_OK, '0);
        directed_rows[18] = row_of(MODE_ALLOC, 32'h3_F001, 32'h0, 1'b0, STAT_OK, '0);
        directed_rows[19] = row_of(MODE_FREE, 32'h0, 32'h0, 1'b0, STAT_OK, '0);
        directed_rows[20] = row_of(MODE_ALLOC, 32'h8000_0000, 32'h0, 1'b1, STAT_NO_SPACE, '0);
        directed_rows[21] = row_of(MODE_FREE, 32'h0, 32'h8000_0000, 1'b1, STAT_BAD_ADDR, '0);

        // upper bits of the narrow registers carry junk in some writes
        phases[0] = phase_of(32'd4096, 32'd64, 32'h0, 0, 0, 110);
        phases[1] = phase_of(32'hFFFE_0001, 32'hFFFF_FF90, 32'hFFFF_FFF0, 79, 0, 90);
        phases[2] = phase_of(32'd0, 32'd8, 32'h1234_5678, 0, 79, 80);
        phases[3] = phase_of(32'h0001_FFFF, 32'd127, 32'hFFFF_0000, 9, 9, 100);
        phases[4] = phase_of(32'd65536, 32'd64, $urandom, 0, 0, 70);
        phases[5] = phase_of(32'd100, 32'd1, $urandom, 79, 0, 40);
        phases[6] = phase_of(32'd4096, 32'd0, 32'h0, 0, 79, 20);
        phases[7] = phase_of($urandom_range(300, 1), $urandom_range(64, 1), $urandom, 9, 9, 140);

        idle_pct  = 0;
        stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
            issue_request(directed_rows[r].mode, directed_rows[r].bytes,
                          directed_rows[r].addr, directed_rows[r]);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            repeat (4) @(posedge clk);
            idle_pct  = phases[p].idle;
            stall_pct = phases[p].stall;
            write_register(CFG_PAGE_BYTES, phases[p].page_bytes_word);
            write_register(CFG_PAGES_IN_USE, phases[p].pages_word);
            write_register(CFG_POOL_BASE, phases[p].base_word);
            cfg_valid <= 1'b0;

            for (int it = 0; it < phases[p].items; it++)
            begin
                pb    = (page_bytes_reg == '0) ? 64'd1 : {47'd0, page_bytes_reg};
                cnt   = (pages_reg > 7'd64) ? MAX_PAGES : int'(pages_reg);
                roll  = $urandom_range(99, 0);
                bytes = $urandom;
                addr  = $urandom;
                if (roll < 45)
                begin
                    m    = MODE_ALLOC;
                    n    = ($urandom_range(3, 0) == 0 && cnt > 0) ? $urandom_range(cnt, 1)
                                                                  : $urandom_range(4, 1);
                    wide = (n - 1) * pb + $urandom_range(pb[31:0] - 1, 0) + 1;
                    bytes = wide[31:0];
                end
                else if (roll < 80)
                begin
                    m = MODE_FREE;
                    if (granted_bases.size() != 0 && $urandom_range(1, 0) == 1)
                    begin
                        j    = $urandom_range(granted_bases.size() - 1, 0);
                        addr = granted_bases[j];
                        granted_bases.delete(j);
                    end
                    else
                    begin
                        wide = {32'd0, pool_base_reg} + $urandom_range(cnt, 0) * pb;
                        addr = wide[31:0];
                    end
                end
                else if (roll < 85)
                begin
                    m     = MODE_ALLOC;
                    bytes = '0;
                end
                else if (roll < 90)
                    m = MODE_ALLOC;
                else if (roll < 95)
                    m = MODE_FREE;
                else
                begin
                    // misaligned free, one to page-1 bytes past a page start
                    m = MODE_FREE;
                    if (pb > 1)
                    begin
                        wide = {32'd0, pool_base_reg} + $urandom_range(cnt, 0) * pb
                               + $urandom_range(pb[31:0] - 1, 1);
                        addr = wide[31:0];
                    end
                end
                issue_request(m, bytes, addr, no_pin);
                pause_sender();
            end
        end

        drain_results();
        repeat (200) @(posedge clk);

        $display("Ran %0d requests: directed list plus %0d pool settings.",
                 requests_sent, NUM_PHASES);
        $display("Results by status: ok %0d, no space %0d, zero size %0d, bad address %0d.",
                 status_seen[STAT_OK], status_seen[STAT_NO_SPACE],
                 status_seen[STAT_ZERO_SIZE], status_seen[STAT_BAD_ADDR]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
